// File: src/pcsu_pkg.sv
// shared types, codes and constants of the pulse channel sweep unit
package pcsu_pkg;

    // operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_SWEEP_WRITE  = 2'd0,
        OP_PERIOD_WRITE = 2'd1,
        OP_SWEEP_TICK   = 2'd2,
        OP_SAMPLE_QUERY = 2'd3
    } t_op;

    localparam logic [11:0] PERIOD_MAX = 12'hFFF;
    localparam logic [11:0] PERIOD_MIN_SWEEP = 12'd7;

    // duty waveforms, bit {mode, step} of this word is the waveform bit
    localparam logic [31:0] DUTY_TABLE = {8'hF9, 8'h1E, 8'h06, 8'h02};

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // one input transaction
    typedef struct packed {
        t_op         op;
        logic [11:0] data;
        logic        channel_active;
        logic [3:0]  volume;
        logic [1:0]  duty_mode;
        logic [2:0]  duty_step;
    } t_item;

    // one result transaction
    typedef struct packed {
        logic [3:0]  sample_value;
        logic [11:0] period;
        logic        sweep_clamped;
        logic        muted;
    } t_result;

    // sweep channel state
    typedef struct packed {
        logic [11:0] timer_period;
        logic [2:0]  shift_amount;
        logic        sweep_down;
        logic [3:0]  update_rate;
        logic        sweep_enabled;
        logic [3:0]  divider_count;
        logic        clamp_flag;
        logic        reload_pending;
    } t_state;

endpackage

// File: src/pcsu_step.sv
// next state and result of one item, combinational
module pcsu_step
    import pcsu_pkg::*;
(
    input  t_state  i_state,
    input  t_item   i_item,
    input  logic    i_channel_number,
    output t_state  o_state,
    output t_result o_result
);

    logic [12:0] w_sum;
    logic [11:0] w_delta;
    logic        w_expire;
    logic        w_apply;
    logic        w_duty_bit;

    // shifted period and upward sum shared by tick and query
    assign w_delta    = i_state.timer_period >> i_state.shift_amount;
    assign w_sum      = {1'b0, i_state.timer_period} + {1'b0, w_delta};
    assign w_expire   = (i_state.divider_count <= 4'd1);
    assign w_apply    = w_expire && i_state.sweep_enabled &&
                        (i_state.shift_amount != 3'd0) &&
                        (i_state.timer_period > PERIOD_MIN_SWEEP);
    assign w_duty_bit = DUTY_TABLE[{i_item.duty_mode, i_item.duty_step}];

    // state update per operation
    always_comb begin
        o_state = i_state;
        o_result.sample_value = 4'd0;
        o_result.muted        = 1'b0;
        unique case (i_item.op)
            OP_SWEEP_WRITE: begin
                o_state.shift_amount   = i_item.data[2:0];
                o_state.sweep_down     = i_item.data[3];
                o_state.update_rate    = {1'b0, i_item.data[6:4]} + 4'd1;
                o_state.sweep_enabled  = i_item.data[7];
                o_state.reload_pending = 1'b1;
            end
            OP_PERIOD_WRITE: begin
                o_state.timer_period = i_item.data;
            end
            OP_SWEEP_TICK: begin
                if (w_expire) begin
                    o_state.divider_count = i_state.update_rate;
                end else begin
                    o_state.divider_count = i_state.divider_count - 4'd1;
                end
                if (w_apply) begin
                    o_state.clamp_flag = 1'b0;
                    if (!i_state.sweep_down) begin
                        if (w_sum[12]) begin
                            o_state.timer_period = PERIOD_MAX;
                            o_state.clamp_flag   = 1'b1;
                        end else begin
                            o_state.timer_period = w_sum[11:0];
                        end
                    end else begin
                        o_state.timer_period = i_state.timer_period - w_delta +
                                               {11'd0, i_channel_number};
                    end
                end
                if (i_state.reload_pending) begin
                    o_state.reload_pending = 1'b0;
                    o_state.divider_count  = i_state.update_rate;
                end
            end
            OP_SAMPLE_QUERY: begin
                if (!i_item.channel_active) begin
                    o_result.muted = 1'b1;
                end else if (!i_state.sweep_down && w_sum[12]) begin
                    o_result.muted = 1'b1;
                end else if (w_duty_bit) begin
                    o_result.sample_value = i_item.volume;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
        o_result.period        = o_state.timer_period;
        o_result.sweep_clamped = o_state.clamp_flag;
    end

endmodule

// File: src/pulse_channel_sweep_unit_core.sv
// top level of the pulse channel sweep unit
// Sweep and output stage of one square-wave channel. Each input transaction
// carries an operation in tuser (sweep register write, period write, sweep
// tick, sample query) and gives exactly one result transaction with the
// sample level, the timer period after the item, the clamp flag and a mute
// flag. The unit takes one transaction per clock while the output does not
// stall: an input register feeds a single combinational step that updates
// the sweep state and loads the result register in the same cycle. The
// result register parts the two sides, and a stalled output holds its
// transaction while one more input is held in the input register.
// channel_number is written through i_cfg_we only while the unit is idle;
// the user must keep to this, as the unit itself does not enforce it.
module pulse_channel_sweep_unit_core
    import pcsu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // data[11:0], channel_active[12], volume[16:13], duty_mode[18:17],
    // duty_step[21:19], zero fill[23:22]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // sample_value[3:0], period[15:4], sweep_clamped[16], muted[17],
    // zero fill[23:18]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic    r_channel_number;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_item   w_item;
    logic    w_advance;

    // unpack the input transaction
    always_comb begin
        w_item.op             = t_op'(s_axis_tuser);
        w_item.data           = s_axis_tdata[11:0];
        w_item.channel_active = s_axis_tdata[12];
        w_item.volume         = s_axis_tdata[16:13];
        w_item.duty_mode      = s_axis_tdata[18:17];
        w_item.duty_step      = s_axis_tdata[21:19];
    end

    // handshake control
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - 18){1'b0}}, r_out.muted,
                            r_out.sweep_clamped, r_out.period, r_out.sample_value};

    pcsu_step u_step (
        .i_state          (r_state),
        .i_item           (r_in),
        .i_channel_number (r_channel_number),
        .o_state          (n_state),
        .o_result         (n_result)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_number <= 1'b0;
        end else if (i_cfg_we) begin
            r_channel_number <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= w_item;
        end
    end

    // sweep state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_result;
        end
    end

endmodule

// File: src/pcsu_checker.sv
// port-level checks of the pulse channel sweep unit and their binding
module pcsu_checker
    import pcsu_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result transaction changed");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // with the result register empty the input side never stalls
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // a muted query carries no level
    a_muted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[17] |-> m_axis_tdata[3:0] == 4'd0)
        else $error("muted result with nonzero sample");

endmodule

bind pulse_channel_sweep_unit_core pcsu_checker u_pcsu_checker (.*);

// File: verif/pulse_sweep_checker.sv
// checker that predicts and compares the pulse channel sweep unit transactions
`timescale 1ns / 100ps

module pulse_sweep_checker
    import pcsu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    // data[11:0], channel_active[12], volume[16:13], duty_mode[18:17],
    // duty_step[21:19], zero fill[23:22]
    input  logic [IN_DATA_W-1:0]  i_in_data,
    // op[1:0]
    input  logic [1:0]            i_in_user,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    // sample_value[3:0], period[15:4], sweep_clamped[16], muted[17],
    // zero fill[23:18]
    input  logic [OUT_DATA_W-1:0] i_out_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    // duty waveforms, one byte per mode, bit index is the step
    localparam logic [31:0] WAVE_BITS = {8'b1111_1001, 8'b0001_1110,
                                         8'b0000_0110, 8'b0000_0010};

    t_state  sweep;
    logic    chan_num;
    t_result levels_due[$];
    int      mismatches;

    assign o_fail_count = mismatches;

    // advance the channel state by one item and return its result
    function automatic t_result step_sweep_channel(input t_item it);
        t_result     r;
        logic [12:0] sum;
        logic [11:0] delta;
        r = '0;
        case (it.op)
            OP_SWEEP_WRITE: begin
                sweep.shift_amount   = it.data[2:0];
                sweep.sweep_down     = it.data[3];
                sweep.update_rate    = {1'b0, it.data[6:4]} + 4'd1;
                sweep.sweep_enabled  = it.data[7];
                sweep.reload_pending = 1'b1;
            end
            OP_PERIOD_WRITE: begin
                sweep.timer_period = it.data;
            end
            OP_SWEEP_TICK: begin
                if (sweep.divider_count <= 4'd1) begin
                    sweep.divider_count = sweep.update_rate;
                    if (sweep.sweep_enabled && sweep.shift_amount != 3'd0 &&
                        sweep.timer_period > PERIOD_MIN_SWEEP) begin
                        delta = sweep.timer_period >> sweep.shift_amount;
                        sweep.clamp_flag = 1'b0;
                        if (!sweep.sweep_down) begin
                            sum = {1'b0, sweep.timer_period} + {1'b0, delta};
                            if (sum > {1'b0, PERIOD_MAX}) begin
                                sweep.timer_period = PERIOD_MAX;
                                sweep.clamp_flag   = 1'b1;
                            end else begin
                                sweep.timer_period = sum[11:0];
                            end
                        end else begin
                            // channel number is added back on the way down
                            sweep.timer_period = sweep.timer_period - delta +
                                                 {11'd0, chan_num};
                        end
                    end
                end else begin
                    sweep.divider_count = sweep.divider_count - 4'd1;
                end
                // a pending reload wins over the countdown
                if (sweep.reload_pending) begin
                    sweep.reload_pending = 1'b0;
                    sweep.divider_count  = sweep.update_rate;
                end
            end
            default: begin
                // overflow mute looks only at direction, not enable or shift
                sum = {1'b0, sweep.timer_period} +
                      {1'b0, sweep.timer_period >> sweep.shift_amount};
                if (!it.channel_active) begin
                    r.muted = 1'b1;
                end else if (!sweep.sweep_down && sum > {1'b0, PERIOD_MAX}) begin
                    r.muted = 1'b1;
                end else if (WAVE_BITS[{it.duty_mode, it.duty_step}]) begin
                    r.sample_value = it.volume;
                end
            end
        endcase
        r.period        = sweep.timer_period;
        r.sweep_clamped = sweep.clamp_flag;
        return r;
    endfunction

    // one field comparison
    function automatic void check_field(input string name, input int want,
                                        input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // watch config port and both stream sides
    always @(posedge i_clk) begin : watch_channels
        t_item   item;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            sweep    = '0;
            chan_num = 1'b0;
            levels_due.delete();
        end else begin
            if (i_cfg_we) begin
                chan_num = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                got.sample_value  = i_out_data[3:0];
                got.period        = i_out_data[15:4];
                got.sweep_clamped = i_out_data[16];
                got.muted         = i_out_data[17];
                if (levels_due.size() == 0) begin
                    $error("result transaction with no item waiting, period %0d",
                           got.period);
                    mismatches++;
                end else begin
                    want = levels_due.pop_front();
                    check_field("sample_value", want.sample_value, got.sample_value);
                    check_field("period", want.period, got.period);
                    check_field("sweep_clamped", want.sweep_clamped, got.sweep_clamped);
                    check_field("muted", want.muted, got.muted);
                end
            end
            if (i_in_valid && i_in_ready) begin
                item.op             = t_op'(i_in_user);
                item.data           = i_in_data[11:0];
                item.channel_active = i_in_data[12];
                item.volume         = i_in_data[16:13];
                item.duty_mode      = i_in_data[18:17];
                item.duty_step      = i_in_data[21:19];
                levels_due.push_back(step_sweep_channel(item));
            end
        end
        o_pending <= levels_due.size();
    end

endmodule

// File: verif/tb_pulse_channel_sweep_unit_core.sv
// testbench top for the pulse channel sweep unit: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_pulse_channel_sweep_unit_core
    import pcsu_pkg::*;
;

    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic                  i_cfg_wdata = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic [1:0]            s_tuser     = OP_SWEEP_WRITE;
    logic                  m_tready    = 1'b0;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int pending;
    int fail_count;
    int idle_cycles = 0;
    int op_count[4] = '{0, 0, 0, 0};
    int cfg_writes  = 0;
    bit no_idle     = 1'b0;

    always #5 i_clk = ~i_clk;

    pulse_channel_sweep_unit_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pulse_sweep_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_tdata),
        .i_in_user    (s_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // idle length for one transaction, zero during burst stretches
    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    // present one item and hold it until the block takes it
    task automatic send_op(input t_op op, input logic [11:0] data,
                           input logic act, input logic [3:0] vol,
                           input logic [1:0] mode, input logic [2:0] step);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, step, mode, vol, act, data};
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        op_count[op]++;
    endtask

    // stop sending and wait until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // channel number write, only with the block idle
    task automatic set_channel(input logic value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    // random items, mostly ticks and queries around live sweep settings
    task automatic run_random(input int count);
        int          pick;
        logic [11:0] data;
        t_op         op;
        for (int n = 0; n < count; n++) begin
            if (n % 25 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            data = 12'($urandom());
            if (pick < 12) begin
                op = OP_SWEEP_WRITE;
                data[7] = ($urandom_range(0, 4) != 0);
                if ($urandom_range(0, 1)) begin
                    data[6:4] = 3'($urandom_range(0, 1));
                end
            end else if (pick < 27) begin
                op = OP_PERIOD_WRITE;
                case ($urandom_range(0, 3))
                    0: data = 12'($urandom_range(0, 16));
                    1: data = 12'($urandom_range(3900, 4095));
                    2: data = 12'($urandom_range(1500, 3000));
                    default: data = 12'($urandom());
                endcase
            end else if (pick < 65) begin
                op = OP_SWEEP_TICK;
            end else begin
                op = OP_SAMPLE_QUERY;
            end
            send_op(op, data, $urandom_range(0, 5) != 0, 4'($urandom()),
                    2'($urandom()), 3'($urandom()));
        end
        no_idle = 1'b0;
    endtask

    // result side stalls
    initial begin : result_sink
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // main stimulus sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_channel(1'b0);

        // query at zero period, inactive mute, overflow mute with no sweep
        send_op(OP_PERIOD_WRITE, 12'd0, 1'b1, 4'd0, 2'd0, 3'd0);
        send_op(OP_SAMPLE_QUERY, 12'd0, 1'b1, 4'd15, 2'd0, 3'd1);
        send_op(OP_SAMPLE_QUERY, 12'd0, 1'b0, 4'd15, 2'd0, 3'd1);
        send_op(OP_PERIOD_WRITE, 12'd4095, 1'b1, 4'd0, 2'd0, 3'd0);
        send_op(OP_SAMPLE_QUERY, 12'd0, 1'b1, 4'd15, 2'd3, 3'd7);
        // sweep byte with upper data bits set: shift 7, down, enabled
        send_op(OP_SWEEP_WRITE, 12'hF8F, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_SAMPLE_QUERY, 12'd0, 1'b1, 4'd15, 2'd3, 3'd7);
        send_op(OP_SWEEP_TICK, 12'hFFF, 1'b1, 4'd15, 2'd3, 3'd7);
        // upward sweep that clamps, then overflow mute
        send_op(OP_SWEEP_WRITE, 12'h081, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_PERIOD_WRITE, 12'd3000, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_SWEEP_TICK, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_SAMPLE_QUERY, 12'd0, 1'b1, 4'd9, 2'd1, 3'd1);
        // disabled sweep keeps the clamp flag, then slow rate countdown
        send_op(OP_SWEEP_WRITE, 12'h071, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_PERIOD_WRITE, 12'd2000, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_SWEEP_TICK, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_SWEEP_WRITE, 12'h0F1, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_SWEEP_TICK, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_SWEEP_TICK, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0);
        // period at the sweep threshold, then zero delta clears the clamp
        send_op(OP_PERIOD_WRITE, 12'd7, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_SWEEP_WRITE, 12'h081, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_SWEEP_TICK, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_PERIOD_WRITE, 12'd8, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_SWEEP_WRITE, 12'h087, 1'b0, 4'd0, 2'd0, 3'd0);
        send_op(OP_SWEEP_TICK, 12'd0, 1'b0, 4'd0, 2'd0, 3'd0);
        // duty rows
        send_op(OP_SAMPLE_QUERY, 12'd0, 1'b1, 4'd7, 2'd2, 3'd4);

        set_channel(1'b1);
        run_random(130);
        set_channel(1'b0);
        run_random(130);
        // full pause with no register write
        drain_results();
        run_random(100);
        set_channel(1'b1);
        run_random(140);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("run covered %0d sweep writes, %0d period writes, %0d ticks, %0d queries",
                 op_count[OP_SWEEP_WRITE], op_count[OP_PERIOD_WRITE],
                 op_count[OP_SWEEP_TICK], op_count[OP_SAMPLE_QUERY]);
        $display("channel number set %0d times across both values, with random idle",
                 cfg_writes);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
